@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the date adder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CDA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CDA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/cda_pkg.sv @@
// types, constants and calendar functions for the date adder
`timescale 1ns / 1ps

package cda_pkg;

	localparam int ADD_DAYS_BITS = 16;
	localparam int DAY_W = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W = 14;
	localparam int DOY_W = 9;
	localparam int ADD_W = 16;
	localparam int REM_W = ADD_DAYS_BITS;
	localparam int UNIT_W = (ADD_DAYS_BITS > 18) ? ADD_DAYS_BITS : 18;

	localparam logic [YEAR_W-1:0] YEAR_MAX = {YEAR_W{1'b1}};
	localparam logic [YEAR_W-1:0] YEAR_CYCLE = YEAR_W'(400);
	localparam logic [YEAR_W-1:0] YEAR_BIG_LIMIT = YEAR_MAX - YEAR_CYCLE;
	localparam logic [UNIT_W-1:0] DAYS_400Y = UNIT_W'(146097);
	localparam logic [DOY_W-1:0] DAYS_COMMON = DOY_W'(365);
	localparam logic [DOY_W-1:0] DAYS_LEAP = DOY_W'(366);
	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

	typedef struct packed {
		logic [DAY_W-1:0] start_day;
		logic [MONTH_W-1:0] start_month;
		logic [YEAR_W-1:0] start_year;
		logic [ADD_W-1:0] days_to_add;
	} req_t;

	typedef struct packed {
		logic date_invalid;
		logic is_leap;
		logic [DAY_W-1:0] month_length;
		logic [DOY_W-1:0] day_of_year;
		logic [DOY_W-1:0] days_remaining;
		logic [DAY_W-1:0] new_day;
		logic [MONTH_W-1:0] new_month;
		logic [YEAR_W-1:0] new_year;
	} rsp_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_status_t;

	// leap test from year mod 400
	function automatic logic leap_of(input logic [8:0] ymod);
		logic r;
		r = (ymod == 9'd0) ||
			((ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200) &&
			(ymod != 9'd300));
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = DAY_W'(31);
			4'd4, 4'd6, 4'd9, 4'd11: r = DAY_W'(30);
			4'd2: r = leap ? DAY_W'(29) : DAY_W'(28);
			default: r = '0;
		endcase
		return r;
	endfunction

	// days before month m in a common year
	function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] r;
		case (m)
			4'd1: r = DOY_W'(0);
			4'd2: r = DOY_W'(31);
			4'd3: r = DOY_W'(59);
			4'd4: r = DOY_W'(90);
			4'd5: r = DOY_W'(120);
			4'd6: r = DOY_W'(151);
			4'd7: r = DOY_W'(181);
			4'd8: r = DOY_W'(212);
			4'd9: r = DOY_W'(243);
			4'd10: r = DOY_W'(273);
			4'd11: r = DOY_W'(304);
			4'd12: r = DOY_W'(334);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/calendar_date_add_days.sv @@
// top level of the gregorian date adder with output register
// work per item: the year residue reduction and the date check, then steps of the shared
// unit through 400-year blocks, single years and months
// one request at a time: not ready while an item is in work
// reset: arst_n clears the sequencer state and the output valid at once
`timescale 1ns / 1ps
`include "assert_macros.svh"

module calendar_date_add_days (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input cda_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output cda_pkg::rsp_t rsp
);
	import cda_pkg::*;

	seq_status_t status;
	rsp_t result;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic start;
	logic take;

	assign req_ready = status.idle;
	assign start = req_valid & req_ready;
	assign take = status.done & (~rsp_valid_q | rsp_ready);

	cda_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(req),
		.take(take),
		.status(status),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`CDA_ASSERT_NXT(a_accept_busy, req_valid && req_ready, !req_ready,
		"ready stayed high after a beat was taken")
	`CDA_ASSERT_NXT(a_take_shows, take, rsp_valid, "result not shown after hand-off")

endmodule

@@ rtl/core/cda_alu.sv @@
// shared subtract and compare unit
`timescale 1ns / 1ps

module cda_alu (
	input logic [cda_pkg::UNIT_W-1:0] a,
	input logic [cda_pkg::UNIT_W-1:0] b,
	output logic [cda_pkg::UNIT_W-1:0] diff,
	output logic ge
);
	import cda_pkg::*;

	logic borrow;

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = ~borrow;

endmodule

@@ rtl/core/cda_seq.sv @@
// sequencer stepping the date by years and months through the shared unit
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cda_seq (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cda_pkg::req_t item,
	input logic take,
	output cda_pkg::seq_status_t status,
	output cda_pkg::rsp_t result
);
	import cda_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MOD = 3'd1;
	localparam logic [2:0] S_CHK = 3'd2;
	localparam logic [2:0] S_BIG = 3'd3;
	localparam logic [2:0] S_YEAR = 3'd4;
	localparam logic [2:0] S_MON = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	logic [DAY_W-1:0] d_q;
	logic [MONTH_W-1:0] m_q;
	logic [YEAR_W-1:0] y_q;
	logic [YEAR_W-1:0] ymod_q;
	logic [REM_W-1:0] rem_q;
	logic invalid_q;
	logic leap0_q;
	logic [DAY_W-1:0] mlen0_q;
	logic [DOY_W-1:0] doy_q;
	logic [DOY_W-1:0] drem_q;

	logic [UNIT_W-1:0] op_a;
	logic [UNIT_W-1:0] op_b;
	logic [UNIT_W-1:0] diff;
	logic ge;
	logic leap_cur;
	logic [DAY_W-1:0] mlen_cur;
	logic [DOY_W-1:0] ylen_cur;
	logic [UNIT_W-1:0] left;
	logic [YEAR_W-1:0] y_inc;
	logic [YEAR_W-1:0] ymod_inc;
	logic chk_bad;
	logic [DOY_W-1:0] chk_doy;
	logic rem_zero;

	assign leap_cur = leap_of(ymod_q[8:0]);
	assign mlen_cur = month_len(m_q, leap_cur);
	assign ylen_cur = leap_cur ? DAYS_LEAP : DAYS_COMMON;
	assign left = UNIT_W'(mlen_cur) - UNIT_W'(d_q) + UNIT_W'(1);
	assign y_inc = y_q + YEAR_W'(1);
	assign ymod_inc = (y_q == YEAR_MAX || ymod_q == YEAR_CYCLE - YEAR_W'(1)) ? '0 :
		ymod_q + YEAR_W'(1);
	assign chk_bad = (mlen_cur == '0) || (d_q == '0) || (d_q > mlen_cur);
	assign chk_doy = cum_days(m_q) + DOY_W'(d_q) +
		DOY_W'(leap_cur && (m_q > MONTH_FEB));
	assign rem_zero = (diff == '0);

	always_comb begin
		op_a = UNIT_W'(rem_q);
		op_b = left;
		case (state_q)
			S_MOD: begin
				op_a = UNIT_W'(ymod_q);
				op_b = UNIT_W'(YEAR_CYCLE);
			end
			S_BIG: op_b = DAYS_400Y;
			S_YEAR: op_b = UNIT_W'(ylen_cur);
			default: op_b = left;
		endcase
	end

	cda_alu u_alu (
		.a(op_a),
		.b(op_b),
		.diff(diff),
		.ge(ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (!ge) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (chk_bad || rem_q == '0) begin
						state_q <= S_DONE;
					end else if (d_q == DAY_W'(1) && m_q == MONTH_JAN) begin
						state_q <= S_BIG;
					end else begin
						state_q <= S_MON;
					end
				end
				S_BIG: begin
					if (ge && y_q <= YEAR_BIG_LIMIT) begin
						state_q <= rem_zero ? S_DONE : S_BIG;
					end else begin
						state_q <= S_YEAR;
					end
				end
				S_YEAR: begin
					if (ge) begin
						state_q <= rem_zero ? S_DONE : S_BIG;
					end else begin
						state_q <= S_MON;
					end
				end
				S_MON: begin
					if (ge && !rem_zero) begin
						state_q <= (m_q == MONTH_DEC) ? S_BIG : S_MON;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					d_q <= item.start_day;
					m_q <= item.start_month;
					y_q <= item.start_year;
					ymod_q <= item.start_year;
					rem_q <= REM_W'(item.days_to_add);
				end
			end
			S_MOD: begin
				if (ge) begin
					ymod_q <= YEAR_W'(diff);
				end
			end
			S_CHK: begin
				invalid_q <= chk_bad;
				leap0_q <= leap_cur;
				mlen0_q <= mlen_cur;
				doy_q <= chk_doy;
				drem_q <= ylen_cur - chk_doy;
			end
			S_BIG: begin
				if (ge && y_q <= YEAR_BIG_LIMIT) begin
					rem_q <= REM_W'(diff);
					y_q <= y_q + YEAR_CYCLE;
				end
			end
			S_YEAR: begin
				if (ge) begin
					rem_q <= REM_W'(diff);
					y_q <= y_inc;
					ymod_q <= ymod_inc;
				end
			end
			S_MON: begin
				if (ge) begin
					rem_q <= REM_W'(diff);
					d_q <= DAY_W'(1);
					if (m_q == MONTH_DEC) begin
						m_q <= MONTH_JAN;
						y_q <= y_inc;
						ymod_q <= ymod_inc;
					end else begin
						m_q <= m_q + MONTH_W'(1);
					end
				end else begin
					d_q <= d_q + DAY_W'(rem_q);
					rem_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign status.idle = (state_q == S_IDLE);
	assign status.done = (state_q == S_DONE);

	always_comb begin
		result = '0;
		result.date_invalid = invalid_q;
		if (!invalid_q) begin
			result.is_leap = leap0_q;
			result.month_length = mlen0_q;
			result.day_of_year = doy_q;
			result.days_remaining = drem_q;
			result.new_day = d_q;
			result.new_month = m_q;
			result.new_year = y_q;
		end
	end

	`CDA_ASSERT_IMP(a_ymod_range, state_q == S_BIG || state_q == S_YEAR || state_q == S_MON,
		ymod_q < YEAR_CYCLE, "year residue out of range")
	`CDA_ASSERT_IMP(a_loop_date_ok, state_q == S_BIG || state_q == S_YEAR || state_q == S_MON,
		d_q != '0 && m_q != '0 && m_q <= MONTH_DEC, "date lost range while stepping")
	`CDA_ASSERT_NXT(a_mon_short_ends, state_q == S_MON && !ge,
		state_q == S_DONE && rem_q == '0, "short month step did not finish")

endmodule
